@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, held off during reset
`define BMH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, named for properties that look ahead to the next cycle
`define BMH_ASSERT_NEXT(lbl, clk, rst_n, prop, msg) \
    `BMH_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

@@ rtl/bmh_pkg.sv @@
// Shared constants, types and state codes for the min-heap builder
package bmh_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 7;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEEP,
        ST_SIFT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic move;
        logic take_right;
    } pick_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        addr_t raddr_a;
        addr_t raddr_b;
    } mem_req_t;

    typedef struct packed {
        logic           strobe;
        logic [POS_W-1:0] position;
        logic           final_res;
        logic           overflow;
    } emit_t;

endpackage

@@ rtl/bmh_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bmh_pick.sv @@
// Smaller-child selection for one sift-down step
module bmh_pick (
    input  bmh_pkg::data_t x,
    input  bmh_pkg::data_t left_val,
    input  bmh_pkg::data_t right_val,
    input  logic           left_ok,
    input  logic           right_ok,
    output bmh_pkg::pick_t pick
);
    import bmh_pkg::*;

    logic  lt_left;
    logic  lt_right;
    data_t best_val;

    // left wins ties: right must be strictly smaller than the current best
    always_comb
    begin
        lt_left         = left_ok && (signed'(left_val) < signed'(x));
        best_val        = lt_left ? left_val : x;
        lt_right        = right_ok && (signed'(right_val) < signed'(best_val));
        pick.move       = lt_left || lt_right;
        pick.take_right = lt_right;
    end

endmodule

@@ rtl/bmh_ctrl.sv @@
// Load, sift-down and emit sequencer around the heap memory
module bmh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bmh_pkg::data_t    value_in,
    input  logic              last,
    output logic              busy,
    output bmh_pkg::mem_req_t req,
    input  bmh_pkg::data_t    a_rdata,
    input  bmh_pkg::data_t    b_rdata,
    output bmh_pkg::emit_t    emit
);
    import bmh_pkg::*;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   drop_reg, drop_next;
    cnt_t   n_reg, n_next;
    cnt_t   k_reg, k_next;
    cnt_t   node_reg, node_next;
    data_t  x_reg, x_next;
    cnt_t   emit_reg, emit_next;
    emit_t  word_reg, word_next;

    logic             room;
    cnt_t             n_new;
    logic [CNT_W:0]   left;
    logic [CNT_W:0]   right;
    logic [CNT_W:0]   n_ext;
    logic [CNT_W:0]   best;
    logic [CNT_W+1:0] best_left;
    logic             left_ok;
    logic             right_ok;
    pick_t            pick;

    assign room      = count_reg < CNT_W'(DEPTH);
    assign n_new     = room ? count_reg + CNT_W'(1) : count_reg;
    assign left      = {node_reg, 1'b0};
    assign right     = {node_reg, 1'b1};
    assign n_ext     = {1'b0, n_reg};
    assign left_ok   = left <= n_ext;
    assign right_ok  = right <= n_ext;
    assign best      = pick.take_right ? right : left;
    assign best_left = {best, 1'b0};

    bmh_pick u_pick (
        .x         (x_reg),
        .left_val  (a_rdata),
        .right_val (b_rdata),
        .left_ok   (left_ok),
        .right_ok  (right_ok),
        .pick      (pick)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && last)
                begin
                    state_next = ((n_new >> 1) == '0) ? ST_EMIT : ST_KEEP;
                end
            end
            ST_KEEP:
            begin
                state_next = ST_SIFT;
            end
            ST_SIFT:
            begin
                if (!pick.move)
                begin
                    state_next = (k_reg == CNT_W'(1)) ? ST_EMIT : ST_KEEP;
                end
            end
            ST_EMIT:
            begin
                if (emit_reg == n_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory requests
    always_comb
    begin
        req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req.we      = start && room;
                req.waddr   = ADDR_W'(count_reg);
                req.wdata   = value_in;
                req.raddr_a = ADDR_W'((n_new >> 1) - CNT_W'(1));
            end
            ST_KEEP:
            begin
                req.raddr_a = ADDR_W'(left - (CNT_W+1)'(1));
                req.raddr_b = ADDR_W'(left);
            end
            ST_SIFT:
            begin
                req.we    = 1'b1;
                req.waddr = ADDR_W'(node_reg - CNT_W'(1));
                if (pick.move)
                begin
                    req.wdata   = pick.take_right ? b_rdata : a_rdata;
                    req.raddr_a = ADDR_W'(best_left - (CNT_W+2)'(1));
                    req.raddr_b = ADDR_W'(best_left);
                end
                else
                begin
                    req.wdata   = x_reg;
                    req.raddr_a = ADDR_W'(k_reg - CNT_W'(2));
                end
            end
            ST_EMIT:
            begin
                req.raddr_a = ADDR_W'(emit_reg - CNT_W'(1));
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        node_next  = node_reg;
        x_next     = x_reg;
        emit_next  = emit_reg;
        word_next  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    count_next = last ? '0 : n_new;
                    drop_next  = drop_reg || !room;
                    if (last)
                    begin
                        n_next    = n_new;
                        k_next    = n_new >> 1;
                        node_next = n_new >> 1;
                        emit_next = CNT_W'(1);
                    end
                end
            end
            ST_KEEP:
            begin
                x_next = a_rdata;
            end
            ST_SIFT:
            begin
                if (pick.move)
                begin
                    node_next = CNT_W'(best);
                end
                else
                begin
                    k_next    = k_reg - CNT_W'(1);
                    node_next = k_reg - CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                emit_next           = emit_reg + CNT_W'(1);
                word_next.strobe    = 1'b1;
                word_next.position  = POS_W'(emit_reg);
                word_next.final_res = emit_reg == n_reg;
                word_next.overflow  = drop_reg;
                if (emit_reg == n_reg)
                begin
                    drop_next = 1'b0;
                end
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        node_reg <= node_next;
        x_reg    <= x_next;
        emit_reg <= emit_next;
    end

    assign busy = state_reg != ST_IDLE;
    assign emit = word_reg;

endmodule

@@ rtl/build_min_heap_unit.sv @@
// Min-heap builder: loads words, sifts them into heap order, then streams them out
// Load: one word per cycle, busy stays low until the word marked last.
// Build: per node from n/2 down to 1, a KEEP state and then SIFT states until the node settles; each
// step is one read of both children from the mirrored heap RAMs and one write back.
// Emit: n results on consecutive cycles after the build ends.
// Reset clears count, drop flag and sequencer; heap memory is not cleared.
module build_min_heap_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [bmh_pkg::VALUE_W-1:0] value,
    input  logic                               last,
    output logic                               busy,
    output logic                               strobe,
    output logic signed [bmh_pkg::VALUE_W-1:0] value_res,
    output logic [bmh_pkg::POS_W-1:0]          position,
    output logic                               final_res,
    output logic                               overflow
);
    import bmh_pkg::*;

    mem_req_t req;
    data_t    a_rdata;
    data_t    b_rdata;
    emit_t    emit;

    bmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value_in (value[DATA_WIDTH-1:0]),
        .last     (last),
        .busy     (busy),
        .req      (req),
        .a_rdata  (a_rdata),
        .b_rdata  (b_rdata),
        .emit     (emit)
    );

    bmh_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr_a),
        .rdata (a_rdata)
    );

    bmh_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr_b),
        .rdata (b_rdata)
    );

    assign strobe    = emit.strobe;
    assign value_res = VALUE_W'(signed'(a_rdata));
    assign position  = emit.position;
    assign final_res = emit.final_res;
    assign overflow  = emit.overflow;

endmodule

@@ rtl/bmh_chk.sv @@
// Port-level checks for the min-heap builder, bound to the top level
`include "assert_macros.svh"

module bmh_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      last,
    input logic                      busy,
    input logic                      strobe,
    input logic [bmh_pkg::POS_W-1:0] position,
    input logic                      final_res,
    input logic                      overflow
);
    import bmh_pkg::*;

    property p_stream_busy;
        (strobe && !final_res) |-> busy;
    endproperty

    property p_stream_step;
        (strobe && !final_res) |=> (strobe && position == $past(position) + POS_W'(1));
    endproperty

    property p_final_ends;
        (strobe && final_res) |=> !strobe;
    endproperty

    property p_load_idle;
        (start && !busy && !last) |=> !busy;
    endproperty

    property p_ovf_steady;
        (strobe && !final_res) |=> (overflow == $past(overflow));
    endproperty

    `BMH_ASSERT(a_stream_busy, clk, rst_n, p_stream_busy, "word stream left busy")
    `BMH_ASSERT_NEXT(a_stream_step, clk, rst_n, p_stream_step, "heap positions not consecutive")
    `BMH_ASSERT_NEXT(a_final_ends, clk, rst_n, p_final_ends, "word after final")
    `BMH_ASSERT_NEXT(a_load_idle, clk, rst_n, p_load_idle, "busy after plain load")
    `BMH_ASSERT_NEXT(a_ovf_steady, clk, rst_n, p_ovf_steady, "overflow changed within set")

endmodule

bind build_min_heap_unit bmh_chk u_bmh_chk (.*);
